// ===== hw/rtl/textured_quad_clipper_macros.svh =====
// Assertion helpers shared by the checker.
`ifndef TEXTURED_QUAD_CLIPPER_MACROS_SVH
`define TEXTURED_QUAD_CLIPPER_MACROS_SVH

// Clocked assertion, masked while reset is held.
`define TQC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define TQC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/tqc_pkg.sv =====
package tqc_pkg;

    localparam int DIV_STAGES = 32;
    localparam int PIPE_DEPTH = DIV_STAGES + 2;

    localparam logic signed [15:0] CLIP_LEFT_RST   = -16'sd32768;
    localparam logic signed [15:0] CLIP_TOP_RST    = -16'sd32768;
    localparam logic signed [15:0] CLIP_RIGHT_RST  = 16'sd32767;
    localparam logic signed [15:0] CLIP_BOTTOM_RST = 16'sd32767;

    typedef enum logic [1:0] {
        REG_CLIP_LEFT,
        REG_CLIP_TOP,
        REG_CLIP_RIGHT,
        REG_CLIP_BOTTOM
    } t_reg_idx;

    typedef enum logic [1:0] {
        EDGE_LEFT,
        EDGE_RIGHT,
        EDGE_TOP,
        EDGE_BOTTOM
    } t_edge;

    // Values that ride alongside the dividers.
    typedef struct packed {
        logic               kept;
        logic               last;
        logic signed [15:0] l;
        logic signed [15:0] r;
        logic signed [15:0] t;
        logic signed [15:0] b;
        logic [15:0]        ul;
        logic [15:0]        ur;
        logic [15:0]        vt;
        logic [15:0]        vb;
    } t_tex;

    typedef struct packed {
        t_tex               tex;
        logic [15:0]        el;
        logic [15:0]        er;
        logic [15:0]        et;
        logic [15:0]        eb;
        logic signed [16:0] xs;
        logic signed [16:0] ys;
        logic signed [16:0] us;
        logic signed [16:0] vs;
    } t_setup;

    typedef struct packed {
        logic [31:0] dvd;
        logic [15:0] dsr;
        logic        neg;
        logic        zero;
    } t_div_in;

endpackage

// ===== hw/rtl/textured_quad_clipper.sv =====
// Textured rectangle clipper.
// Input channel: i_in_valid / o_in_stall carry one rectangle word (four Q12.4
// edges, four Q1.15 texture coordinates, batch end flag). A word is taken at a
// rising edge with i_in_valid high and o_in_stall low.
// Output channel: o_out_valid / i_out_stall carry one clipped word per input
// word, in order, with o_kept low (and all geometry zero) for rejected ones.
// Clip window: four registers on the APB-style port at byte 0, 4, 8, 12
// (left, top, right, bottom); write them only while the block is idle.
// Throughput: one word per cycle while i_out_stall does not hold the output; the
// depth comes from the 32-stage restoring dividers that scale the texture shift,
// one quotient bit per stage, four dividers side by side.
// Reset: synchronous, active low; clears all valid bits and loads the window
// to the full Q12.4 range. Payload registers are not reset.
// Stall: while a result sits on the output and i_out_stall is high the whole
// pipeline holds and o_in_stall rises; bubbles hold their place too, so the
// input can stall even when some stages are empty.
module textured_quad_clipper import tqc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [15:0] i_pos_left,
    input  logic signed [15:0] i_pos_right,
    input  logic signed [15:0] i_pos_top,
    input  logic signed [15:0] i_pos_bottom,
    input  logic [15:0]        i_tex_u_left,
    input  logic [15:0]        i_tex_u_right,
    input  logic [15:0]        i_tex_v_top,
    input  logic [15:0]        i_tex_v_bottom,
    input  logic               i_batch_end_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [15:0] o_out_left,
    output logic signed [15:0] o_out_right,
    output logic signed [15:0] o_out_top,
    output logic signed [15:0] o_out_bottom,
    output logic [15:0]        o_out_u_left,
    output logic [15:0]        o_out_u_right,
    output logic [15:0]        o_out_v_top,
    output logic [15:0]        o_out_v_bottom,
    output logic               o_kept,
    output logic               o_batch_end_out
);

    logic signed [15:0] r_win_left;
    logic signed [15:0] r_win_top;
    logic signed [15:0] r_win_right;
    logic signed [15:0] r_win_bottom;
    logic               cfg_wr;
    t_reg_idx           cfg_idx;

    // Valid bits for setup, multiply and divider stages.
    logic               r_vld [PIPE_DEPTH];
    logic               r_out_valid;
    logic               en;

    t_setup             setup;
    t_div_in            div_in [4];
    t_tex               mul_tex;
    t_tex               r_tex [DIV_STAGES];
    logic [15:0]        shift [4];

    logic signed [15:0] r_o_left;
    logic signed [15:0] r_o_right;
    logic signed [15:0] r_o_top;
    logic signed [15:0] r_o_bottom;
    logic [15:0]        r_o_ul;
    logic [15:0]        r_o_ur;
    logic [15:0]        r_o_vt;
    logic [15:0]        r_o_vb;
    logic               r_o_kept;
    logic               r_o_last;

    // ---------------- configuration ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_left   <= CLIP_LEFT_RST;
            r_win_top    <= CLIP_TOP_RST;
            r_win_right  <= CLIP_RIGHT_RST;
            r_win_bottom <= CLIP_BOTTOM_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_CLIP_LEFT:   r_win_left   <= pwdata[15:0];
                REG_CLIP_TOP:    r_win_top    <= pwdata[15:0];
                REG_CLIP_RIGHT:  r_win_right  <= pwdata[15:0];
                REG_CLIP_BOTTOM: r_win_bottom <= pwdata[15:0];
            endcase
        end
    end

    // Read back sign-extended to the bus width.
    always_comb begin
        unique case (cfg_idx)
            REG_CLIP_LEFT:   prdata = 32'(r_win_left);
            REG_CLIP_TOP:    prdata = 32'(r_win_top);
            REG_CLIP_RIGHT:  prdata = 32'(r_win_right);
            REG_CLIP_BOTTOM: prdata = 32'(r_win_bottom);
        endcase
    end

    // ---------------- flow control ----------------
    // Advance everything unless a finished word is held by the receiver.
    assign en         = !(r_out_valid && i_out_stall);
    assign o_in_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < PIPE_DEPTH; k++) begin
                r_vld[k] <= 1'b0;
            end
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_in_valid;
            for (int k = 1; k < PIPE_DEPTH; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
            r_out_valid <= r_vld[PIPE_DEPTH-1];
        end
    end

    // ---------------- datapath ----------------
    // Stage 1: reject test, edge excess, spans.
    tqc_setup u_setup (
        .i_clk          (i_clk),
        .i_en           (en),
        .i_win_left     (r_win_left),
        .i_win_top      (r_win_top),
        .i_win_right    (r_win_right),
        .i_win_bottom   (r_win_bottom),
        .i_pos_left     (i_pos_left),
        .i_pos_right    (i_pos_right),
        .i_pos_top      (i_pos_top),
        .i_pos_bottom   (i_pos_bottom),
        .i_tex_u_left   (i_tex_u_left),
        .i_tex_u_right  (i_tex_u_right),
        .i_tex_v_top    (i_tex_v_top),
        .i_tex_v_bottom (i_tex_v_bottom),
        .i_batch_end_in (i_batch_end_in),
        .o_setup        (setup)
    );

    // Stage 2: excess times texture span, as magnitude and sign.
    tqc_mul u_mul (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_setup (setup),
        .o_div   (div_in),
        .o_tex   (mul_tex)
    );

    // Stages 3..34: one divider per edge, truncating toward zero.
    for (genvar g = 0; g < 4; g++) begin : g_div
        tqc_div u_div (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_div   (div_in[g]),
            .o_shift (shift[g])
        );
    end

    // Carry the untouched fields alongside the dividers.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tex[0] <= mul_tex;
            for (int k = 1; k < DIV_STAGES; k++) begin
                r_tex[k] <= r_tex[k-1];
            end
        end
    end

    // Output register: apply the shifts, zero rejected words.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_kept <= r_tex[DIV_STAGES-1].kept;
            r_o_last <= r_tex[DIV_STAGES-1].last;
            if (r_tex[DIV_STAGES-1].kept) begin
                r_o_left   <= r_tex[DIV_STAGES-1].l;
                r_o_right  <= r_tex[DIV_STAGES-1].r;
                r_o_top    <= r_tex[DIV_STAGES-1].t;
                r_o_bottom <= r_tex[DIV_STAGES-1].b;
                r_o_ul     <= r_tex[DIV_STAGES-1].ul + shift[EDGE_LEFT];
                r_o_ur     <= r_tex[DIV_STAGES-1].ur - shift[EDGE_RIGHT];
                r_o_vt     <= r_tex[DIV_STAGES-1].vt + shift[EDGE_TOP];
                r_o_vb     <= r_tex[DIV_STAGES-1].vb - shift[EDGE_BOTTOM];
            end else begin
                r_o_left   <= 16'sd0;
                r_o_right  <= 16'sd0;
                r_o_top    <= 16'sd0;
                r_o_bottom <= 16'sd0;
                r_o_ul     <= 16'd0;
                r_o_ur     <= 16'd0;
                r_o_vt     <= 16'd0;
                r_o_vb     <= 16'd0;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_left      = r_o_left;
    assign o_out_right     = r_o_right;
    assign o_out_top       = r_o_top;
    assign o_out_bottom    = r_o_bottom;
    assign o_out_u_left    = r_o_ul;
    assign o_out_u_right   = r_o_ur;
    assign o_out_v_top     = r_o_vt;
    assign o_out_v_bottom  = r_o_vb;
    assign o_kept          = r_o_kept;
    assign o_batch_end_out = r_o_last;

endmodule

// ===== hw/rtl/tqc_setup.sv =====
module tqc_setup import tqc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [15:0] i_win_left,
    input  logic signed [15:0] i_win_top,
    input  logic signed [15:0] i_win_right,
    input  logic signed [15:0] i_win_bottom,
    input  logic signed [15:0] i_pos_left,
    input  logic signed [15:0] i_pos_right,
    input  logic signed [15:0] i_pos_top,
    input  logic signed [15:0] i_pos_bottom,
    input  logic [15:0]        i_tex_u_left,
    input  logic [15:0]        i_tex_u_right,
    input  logic [15:0]        i_tex_v_top,
    input  logic [15:0]        i_tex_v_bottom,
    input  logic               i_batch_end_in,
    output t_setup             o_setup
);

    t_setup             r_setup;
    t_setup             n_setup;
    logic signed [16:0] d_l;
    logic signed [16:0] d_r;
    logic signed [16:0] d_t;
    logic signed [16:0] d_b;
    logic               rej;

    always_comb begin
        d_l = {i_win_left[15], i_win_left} - {i_pos_left[15], i_pos_left};
        d_r = {i_pos_right[15], i_pos_right} - {i_win_right[15], i_win_right};
        d_t = {i_win_top[15], i_win_top} - {i_pos_top[15], i_pos_top};
        d_b = {i_pos_bottom[15], i_pos_bottom} - {i_win_bottom[15], i_win_bottom};
        rej = (i_pos_left >= i_win_right) || (i_pos_right <= i_win_left) ||
              (i_pos_top >= i_win_bottom) || (i_pos_bottom <= i_win_top);

        n_setup.tex.kept = !rej;
        n_setup.tex.last = i_batch_end_in;
        n_setup.tex.l    = (d_l > 0) ? i_win_left : i_pos_left;
        n_setup.tex.r    = (d_r > 0) ? i_win_right : i_pos_right;
        n_setup.tex.t    = (d_t > 0) ? i_win_top : i_pos_top;
        n_setup.tex.b    = (d_b > 0) ? i_win_bottom : i_pos_bottom;
        n_setup.tex.ul   = i_tex_u_left;
        n_setup.tex.ur   = i_tex_u_right;
        n_setup.tex.vt   = i_tex_v_top;
        n_setup.tex.vb   = i_tex_v_bottom;
        n_setup.el = (d_l > 0) ? d_l[15:0] : 16'd0;
        n_setup.er = (d_r > 0) ? d_r[15:0] : 16'd0;
        n_setup.et = (d_t > 0) ? d_t[15:0] : 16'd0;
        n_setup.eb = (d_b > 0) ? d_b[15:0] : 16'd0;
        n_setup.xs = {i_pos_right[15], i_pos_right} - {i_pos_left[15], i_pos_left};
        n_setup.ys = {i_pos_bottom[15], i_pos_bottom} - {i_pos_top[15], i_pos_top};
        n_setup.us = $signed({1'b0, i_tex_u_right}) - $signed({1'b0, i_tex_u_left});
        n_setup.vs = $signed({1'b0, i_tex_v_bottom}) - $signed({1'b0, i_tex_v_top});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_setup <= n_setup;
        end
    end

    assign o_setup = r_setup;

endmodule

// ===== hw/rtl/tqc_mul.sv =====
module tqc_mul import tqc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_en,
    input  t_setup  i_setup,
    output t_div_in o_div [4],
    output t_tex    o_tex
);

    t_div_in     r_div [4];
    t_div_in     n_div [4];
    t_tex        r_tex;
    logic [16:0] us_mag;
    logic [16:0] vs_mag;
    logic [16:0] xs_mag;
    logic [16:0] ys_mag;

    always_comb begin
        us_mag = i_setup.us[16] ? 17'(-i_setup.us) : i_setup.us;
        vs_mag = i_setup.vs[16] ? 17'(-i_setup.vs) : i_setup.vs;
        xs_mag = i_setup.xs[16] ? 17'(-i_setup.xs) : i_setup.xs;
        ys_mag = i_setup.ys[16] ? 17'(-i_setup.ys) : i_setup.ys;

        n_div[EDGE_LEFT].dvd    = i_setup.el * us_mag[15:0];
        n_div[EDGE_RIGHT].dvd   = i_setup.er * us_mag[15:0];
        n_div[EDGE_TOP].dvd     = i_setup.et * vs_mag[15:0];
        n_div[EDGE_BOTTOM].dvd  = i_setup.eb * vs_mag[15:0];
        n_div[EDGE_LEFT].dsr    = xs_mag[15:0];
        n_div[EDGE_RIGHT].dsr   = xs_mag[15:0];
        n_div[EDGE_TOP].dsr     = ys_mag[15:0];
        n_div[EDGE_BOTTOM].dsr  = ys_mag[15:0];
        n_div[EDGE_LEFT].neg    = i_setup.us[16] ^ i_setup.xs[16];
        n_div[EDGE_RIGHT].neg   = i_setup.us[16] ^ i_setup.xs[16];
        n_div[EDGE_TOP].neg     = i_setup.vs[16] ^ i_setup.ys[16];
        n_div[EDGE_BOTTOM].neg  = i_setup.vs[16] ^ i_setup.ys[16];
        n_div[EDGE_LEFT].zero   = (i_setup.xs == 17'sd0);
        n_div[EDGE_RIGHT].zero  = (i_setup.xs == 17'sd0);
        n_div[EDGE_TOP].zero    = (i_setup.ys == 17'sd0);
        n_div[EDGE_BOTTOM].zero = (i_setup.ys == 17'sd0);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div <= n_div;
            r_tex <= i_setup.tex;
        end
    end

    assign o_div = r_div;
    assign o_tex = r_tex;

endmodule

// ===== hw/rtl/tqc_div.sv =====
// Restoring divider, one quotient bit per stage, magnitudes in, signed shift out.
module tqc_div import tqc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  t_div_in     i_div,
    output logic [15:0] o_shift
);

    logic [15:0] r_rem  [DIV_STAGES];
    logic [31:0] r_dvd  [DIV_STAGES];
    logic [31:0] r_q    [DIV_STAGES];
    logic [15:0] r_dsr  [DIV_STAGES];
    logic        r_neg  [DIV_STAGES];
    logic        r_zero [DIV_STAGES];
    logic [15:0] n_rem  [DIV_STAGES];
    logic [31:0] n_dvd  [DIV_STAGES];
    logic [31:0] n_q    [DIV_STAGES];
    logic [15:0] n_dsr  [DIV_STAGES];
    logic        n_neg  [DIV_STAGES];
    logic        n_zero [DIV_STAGES];
    logic [16:0] trial  [DIV_STAGES];
    logic        ge     [DIV_STAGES];
    logic [16:0] diff   [DIV_STAGES];
    logic [15:0] q_lo;

    always_comb begin
        for (int k = 0; k < DIV_STAGES; k++) begin
            if (k == 0) begin
                trial[k]  = {16'd0, i_div.dvd[31]};
                n_dvd[k]  = {i_div.dvd[30:0], 1'b0};
                n_dsr[k]  = i_div.dsr;
                n_neg[k]  = i_div.neg;
                n_zero[k] = i_div.zero;
                ge[k]     = trial[k] >= {1'b0, i_div.dsr};
                n_q[k]    = {31'd0, ge[k]};
            end else begin
                trial[k]  = {r_rem[k-1], r_dvd[k-1][31]};
                n_dvd[k]  = {r_dvd[k-1][30:0], 1'b0};
                n_dsr[k]  = r_dsr[k-1];
                n_neg[k]  = r_neg[k-1];
                n_zero[k] = r_zero[k-1];
                ge[k]     = trial[k] >= {1'b0, r_dsr[k-1]};
                n_q[k]    = {r_q[k-1][30:0], ge[k]};
            end
            diff[k]  = trial[k] - {1'b0, n_dsr[k]};
            n_rem[k] = ge[k] ? diff[k][15:0] : trial[k][15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_dvd  <= n_dvd;
            r_q    <= n_q;
            r_dsr  <= n_dsr;
            r_neg  <= n_neg;
            r_zero <= n_zero;
        end
    end

    assign q_lo    = r_q[DIV_STAGES-1][15:0];
    assign o_shift = r_zero[DIV_STAGES-1] ? 16'd0 :
                     (r_neg[DIV_STAGES-1] ? 16'(-q_lo) : q_lo);

endmodule

// ===== hw/rtl/tqc_checker.sv =====
`include "textured_quad_clipper_macros.svh"

module tqc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic signed [15:0] o_out_left,
    input logic signed [15:0] o_out_right,
    input logic signed [15:0] o_out_top,
    input logic signed [15:0] o_out_bottom,
    input logic [15:0]        o_out_u_left,
    input logic [15:0]        o_out_u_right,
    input logic [15:0]        o_out_v_top,
    input logic [15:0]        o_out_v_bottom,
    input logic               o_kept,
    input logic               o_batch_end_out
);

    property p_stall_cause;
        o_in_stall |-> (o_out_valid && i_out_stall);
    endproperty

    property p_rej_zero;
        (o_out_valid && !o_kept) |->
            ((o_out_left == 16'sd0) && (o_out_right == 16'sd0) &&
             (o_out_top == 16'sd0) && (o_out_bottom == 16'sd0) &&
             (o_out_u_left == 16'd0) && (o_out_u_right == 16'd0) &&
             (o_out_v_top == 16'd0) && (o_out_v_bottom == 16'd0));
    endproperty

    property p_out_hold;
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_out_left) && $stable(o_out_u_left) &&
             $stable(o_kept) && $stable(o_batch_end_out));
    endproperty

    // Drop out of reset with an empty output.
    `TQC_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !o_out_valid, "valid after reset")

    // Hold back input only when the output is blocked.
    `TQC_ASSERT(a_stall_cause, i_clk, i_rst_n, p_stall_cause, "stall without cause")

    // Rejected words carry zero geometry.
    `TQC_ASSERT(a_rej_zero, i_clk, i_rst_n, p_rej_zero, "rejected word not zero")

    // A stalled result stays put.
    `TQC_ASSERT(a_out_hold, i_clk, i_rst_n, p_out_hold, "stalled word changed")

endmodule

bind textured_quad_clipper tqc_checker u_tqc_checker (.*);
